// ----- rtl/g2r_pkg.sv -----
// Package for the 2-bit gray to RGBA8888 unpacker.
// Field widths, register indexes and the level expansion functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package g2r_pkg;

    localparam int WORD_W     = 32;
    localparam int PIX_W      = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_CFG_W  = 13;
    localparam int POS_W      = 4;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_ROWS  = 4096;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROW_WIDTH     = 2'd0,
        REG_ROW_TOTAL     = 2'd1,
        REG_START_PIXEL   = 2'd2,
        REG_ALPHA_PRESENT = 2'd3
    } t_reg_idx;

    // Gray level replicated into bytes 3..1, byte 0 left clear.
    function automatic logic [PIX_W-1:0] gray_spread(input logic [1:0] g);
        logic [PIX_W-1:0] v;
        unique case (g)
            2'd0:    v = 32'h0000_0000;
            2'd1:    v = 32'h5555_5500;
            2'd2:    v = 32'hAAAA_AA00;
            default: v = 32'hFFFF_FF00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] alpha_spread(input logic [1:0] a);
        logic [7:0] v;
        unique case (a)
            2'd0:    v = 8'h00;
            2'd1:    v = 8'h55;
            2'd2:    v = 8'hAA;
            default: v = 8'hFF;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/g2r_if.sv -----
// Channel interfaces of the unpacker: source words, pixel beats and
// configuration writes. Depends on g2r_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface g2r_word_if;
    import g2r_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] pixel_word;
    logic [WORD_W-1:0] alpha_word;
    modport source (output valid, output pixel_word, output alpha_word, input ready);
    modport sink   (input valid, input pixel_word, input alpha_word, output ready);
endinterface

interface g2r_pix_if;
    import g2r_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_rgba;
    logic             word_last;
    logic             row_end;
    logic             image_end;
    modport source (output valid, output pixel_rgba, output word_last,
                    output row_end, output image_end, input ready);
    modport sink   (input valid, input pixel_rgba, input word_last,
                    input row_end, input image_end, output ready);
endinterface

interface g2r_cfg_if;
    import g2r_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/gray2_to_rgba32_unpacker_unit.sv -----
// Top level of the 2-bit gray to RGBA8888 unpacker.
// Depends on g2r_pkg and the channel interfaces in g2r_if.sv.
//
// Each accepted source word is unpacked one pixel per cycle, unless the
// output stalls, by a single column/row counter step under a two-state
// sequencer. A word starting at pixel position p yields up to 16 - p beats,
// fewer when the row ends inside the word. No new word is taken until the
// last beat has been made and the sequencer is back in its idle state.
// The last beat sits in the output register while the next word is taken.
// Row width and row count of zero act as one, and values above MAX_WIDTH or
// MAX_ROWS saturate to them. Configuration writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module gray2_to_rgba32_unpacker_unit #(
    parameter int MAX_WIDTH = g2r_pkg::DEF_MAX_WIDTH,
    parameter int MAX_ROWS  = g2r_pkg::DEF_MAX_ROWS
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    g2r_word_if.sink     i_word,
    g2r_pix_if.source    o_pix,
    g2r_cfg_if.sink      i_cfg
);
    import g2r_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_CFG_W-1:0] r_row_width, r_row_total;
    logic [POS_W-1:0]     r_start_pixel;
    logic                 r_alpha_present;

    logic [CW-1:0]        r_col, n_col;
    logic [RW-1:0]        r_row, n_row;
    logic                 r_row_start, n_row_start;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [WORD_W-1:0]    r_gray, r_alpha;

    logic                 r_valid, n_valid;
    logic [PIX_W-1:0]     r_pix, n_pix;
    logic                 r_wlast, n_wlast, r_rend, n_rend, r_iend, n_iend;

    logic [CW-1:0]        w_eff;
    logic [RW-1:0]        rows_eff;
    logic [CW:0]          col_inc;
    logic [RW:0]          row_inc;
    logic [4:0]           bit_idx;
    logic [1:0]           g_lvl, a_lvl;
    logic                 word_acc, step, rend;

    assign i_cfg.ready  = 1'b1;
    assign i_word.ready = (r_state == ST_IDLE);
    assign word_acc     = i_word.valid && (r_state == ST_IDLE);
    assign step         = (r_state == ST_RUN) && (!r_valid || o_pix.ready);

    always_comb begin
        if (r_row_width == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_row_width) > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_row_width);
        end
        if (r_row_total == '0) begin
            rows_eff = RW'(1);
        end else if (32'(r_row_total) > 32'(MAX_ROWS)) begin
            rows_eff = RW'(MAX_ROWS);
        end else begin
            rows_eff = RW'(r_row_total);
        end
    end

    // Pixel 0 sits in bits 31:30, so the low bit of pixel p is 30 - 2p.
    assign bit_idx = 5'd30 - {r_pos, 1'b0};
    assign g_lvl   = r_gray[bit_idx +: 2];
    assign a_lvl   = r_alpha[bit_idx +: 2];
    assign col_inc = {1'b0, r_col} + {{CW{1'b0}}, 1'b1};
    assign row_inc = {1'b0, r_row} + {{RW{1'b0}}, 1'b1};
    assign rend    = (col_inc >= {1'b0, w_eff});

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_row_start = r_row_start;
        n_pos       = r_pos;
        n_valid     = r_valid && !o_pix.ready;
        n_pix       = r_pix;
        n_wlast     = r_wlast;
        n_rend      = r_rend;
        n_iend      = r_iend;

        unique case (r_state)
            ST_IDLE: begin
                if (word_acc) begin
                    n_pos       = r_row_start ? r_start_pixel : '0;
                    n_row_start = 1'b0;
                    n_state     = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step) begin
                    n_valid = 1'b1;
                    n_pix   = gray_spread(g_lvl)
                            | {24'h0, r_alpha_present ? alpha_spread(a_lvl) : 8'hFF};
                    n_rend  = rend;
                    n_wlast = rend || (r_pos == {POS_W{1'b1}});
                    n_iend  = 1'b0;
                    n_pos   = r_pos + POS_W'(1);
                    if (rend) begin
                        n_col       = '0;
                        n_row_start = 1'b1;
                        if (row_inc >= {1'b0, rows_eff}) begin
                            n_iend = 1'b1;
                            n_row  = '0;
                        end else begin
                            n_row = row_inc[RW-1:0];
                        end
                    end else begin
                        n_col = col_inc[CW-1:0];
                    end
                    if (n_wlast) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_valid         <= 1'b0;
            r_col           <= '0;
            r_row           <= '0;
            r_row_start     <= 1'b1;
            r_row_width     <= CNT_CFG_W'(1);
            r_row_total     <= CNT_CFG_W'(1);
            r_start_pixel   <= '0;
            r_alpha_present <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_col       <= n_col;
            r_row       <= n_row;
            r_row_start <= n_row_start;
            if (i_cfg.valid) begin
                unique case (t_reg_idx'(i_cfg.index))
                    REG_ROW_WIDTH:     r_row_width     <= i_cfg.data[CNT_CFG_W-1:0];
                    REG_ROW_TOTAL:     r_row_total     <= i_cfg.data[CNT_CFG_W-1:0];
                    REG_START_PIXEL:   r_start_pixel   <= i_cfg.data[POS_W-1:0];
                    REG_ALPHA_PRESENT: r_alpha_present <= i_cfg.data[0];
                    default:           r_alpha_present <= r_alpha_present;
                endcase
            end
        end
        r_pos   <= n_pos;
        r_pix   <= n_pix;
        r_wlast <= n_wlast;
        r_rend  <= n_rend;
        r_iend  <= n_iend;
        if (word_acc) begin
            r_gray  <= i_word.pixel_word;
            r_alpha <= i_word.alpha_word;
        end
    end

    assign o_pix.valid      = r_valid;
    assign o_pix.pixel_rgba = r_pix;
    assign o_pix.word_last  = r_wlast;
    assign o_pix.row_end    = r_rend;
    assign o_pix.image_end  = r_iend;

endmodule

`default_nettype wire

// ----- tb/gray2_to_rgba32_unpacker_unit_test.sv -----
// Self-checking testbench for the 2-bit gray to RGBA8888 unpacker.
// Drives source words and register writes, predicts every pixel beat and its flags.
// Depends on g2r_pkg, the channel interfaces in g2r_if.sv and the unpacker top level.
`timescale 1ns / 1ps

module gray2_to_rgba32_unpacker_unit_test;
    import g2r_pkg::*;

    localparam int MAX_WIDTH      = DEF_MAX_WIDTH;
    localparam int MAX_ROWS       = DEF_MAX_ROWS;
    localparam int SETTLE_CYCLES  = 20;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 200;
    localparam int QUIET_TAIL     = 40;

    typedef struct packed {
        logic [PIX_W-1:0] rgba;
        logic             word_last;
        logic             row_end;
        logic             image_end;
    } pixel_beat_t;

    logic i_clk;
    logic i_rst_n;

    g2r_word_if word_ch ();
    g2r_pix_if  pix_ch ();
    g2r_cfg_if  cfg_ch ();

    gray2_to_rgba32_unpacker_unit #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (word_ch),
        .o_pix   (pix_ch),
        .i_cfg   (cfg_ch)
    );

    // Register shadow and counter state of the unpacker.
    logic [CNT_CFG_W-1:0] shadow_width;
    logic [CNT_CFG_W-1:0] shadow_rows;
    logic [POS_W-1:0]     shadow_start;
    logic                 shadow_alpha;
    int                   column_pos;
    int                   row_pos;
    bit                   at_row_start;

    pixel_beat_t pending_pixels[$];

    int  mismatch_count;
    int  quiet_cycles;
    int  words_sent;
    bit  tx_gaps;
    bit  rx_gaps;
    bit  rx_long_hold;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int effective_count(input logic [CNT_CFG_W-1:0] value, input int top);
        if (value == '0) return 1;
        if (int'(value) > top) return top;
        return int'(value);
    endfunction

    // Expands one source word into the pixel beats it produces and advances the counters.
    task automatic unpack_word(input logic [WORD_W-1:0] gray_w, input logic [WORD_W-1:0] alpha_w);
        int          width_eff;
        int          rows_eff;
        int          pos;
        logic [1:0]  g;
        logic [1:0]  a;
        logic [7:0]  gray_byte;
        logic [7:0]  alpha_byte;
        bit          row_done;
        pixel_beat_t beat;
        width_eff = effective_count(shadow_width, MAX_WIDTH);
        rows_eff  = effective_count(shadow_rows, MAX_ROWS);
        pos = at_row_start ? int'(shadow_start) : 0;
        at_row_start = 1'b0;
        while (pos < 16) begin
            g = gray_w[(31 - 2 * pos) -: 2];
            a = alpha_w[(31 - 2 * pos) -: 2];
            gray_byte  = {4{g}};
            alpha_byte = shadow_alpha ? {4{a}} : 8'hFF;
            column_pos++;
            row_done = (column_pos >= width_eff);
            beat.rgba      = {gray_byte, gray_byte, gray_byte, alpha_byte};
            beat.word_last = row_done || (pos == 15);
            beat.row_end   = row_done;
            beat.image_end = 1'b0;
            if (row_done) begin
                column_pos = 0;
                row_pos++;
                if (row_pos >= rows_eff) begin
                    beat.image_end = 1'b1;
                    row_pos = 0;
                end
                at_row_start = 1'b1;
            end
            pending_pixels.push_back(beat);
            if (row_done) break;
            pos++;
        end
    endtask

    // Leaves valid high on return so that back-to-back words need no second assignment.
    task automatic send_word(input logic [WORD_W-1:0] gray_w, input logic [WORD_W-1:0] alpha_w);
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            word_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        word_ch.valid      <= 1'b1;
        word_ch.pixel_word <= gray_w;
        word_ch.alpha_word <= alpha_w;
        do @(negedge i_clk); while (!word_ch.ready);
        @(posedge i_clk);
        unpack_word(gray_w, alpha_w);
        words_sent++;
    endtask

    task automatic stop_words();
        word_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every predicted beat has come, then lets the block settle.
    task automatic drain();
        stop_words();
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Unused upper data bits are filled with noise; the block must ignore them.
    task automatic write_reg(input t_reg_idx idx, input logic [CNT_CFG_W-1:0] value);
        logic [CFG_DATA_W-1:0] data;
        data = $urandom;
        case (idx)
            REG_ROW_WIDTH, REG_ROW_TOTAL: data[CNT_CFG_W-1:0] = value;
            REG_START_PIXEL:              data[POS_W-1:0] = value[POS_W-1:0];
            default:                      data[0] = value[0];
        endcase
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        cfg_ch.valid <= 1'b1;
        do @(negedge i_clk); while (!cfg_ch.ready);
        @(posedge i_clk);
        case (idx)
            REG_ROW_WIDTH:   shadow_width = data[CNT_CFG_W-1:0];
            REG_ROW_TOTAL:   shadow_rows  = data[CNT_CFG_W-1:0];
            REG_START_PIXEL: shadow_start = data[POS_W-1:0];
            default:         shadow_alpha = data[0];
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int width, input int rows, input int start, input bit alpha);
        write_reg(REG_ROW_WIDTH, width[CNT_CFG_W-1:0]);
        write_reg(REG_ROW_TOTAL, rows[CNT_CFG_W-1:0]);
        write_reg(REG_START_PIXEL, start[CNT_CFG_W-1:0]);
        write_reg(REG_ALPHA_PRESENT, alpha ? 13'd1 : 13'd0);
    endtask

    // With the reset register values every word gives one pixel that ends the image.
    task automatic test_reset_defaults();
        send_word(32'h0000_0000, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'h0000_0000);
        send_word(32'h1B1B_1B1B, $urandom);
        drain();
    endtask

    task automatic test_levels_and_offsets();
        configure(16, 2, 0, 1'b1);
        send_word(32'h1B1B_1B1B, 32'hE4E4_E4E4);
        send_word(32'hFFFF_FFFF, 32'h0000_0000);
        send_word(32'h0000_0000, 32'hFFFF_FFFF);
        send_word(32'hE4E4_E4E4, 32'h1B1B_1B1B);
        drain();
        // Offset 15 takes one pixel from the first word, so the row ends inside the next one.
        configure(16, 1, 15, 1'b0);
        send_word(32'h4000_0003, 32'hFFFF_FFFF);
        send_word(32'h1B1B_1B1B, 32'h0000_0000);
        send_word(32'hC000_0001, 32'h5555_5555);
        drain();
    endtask

    task automatic test_zero_and_oversized();
        configure(0, 0, 7, 1'b1);
        send_word(32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_word($urandom, $urandom);
        drain();
        // Oversized width saturates, so two words stay inside the first row.
        configure(8191, 8191, 0, 1'b1);
        send_word($urandom, $urandom);
        send_word($urandom, $urandom);
        drain();
        configure(MAX_WIDTH, MAX_ROWS, 3, 1'b0);
        send_word($urandom, $urandom);
        drain();
    endtask

    // Counters survive register writes, so a shrunk width ends the row at once.
    task automatic test_change_mid_image();
        configure(40, 3, 0, 1'b0);
        send_word($urandom, $urandom);
        drain();
        configure(5, 3, 0, 1'b1);
        send_word($urandom, $urandom);
        send_word($urandom, $urandom);
        drain();
        configure(5, 1, 9, 1'b1);
        send_word($urandom, $urandom);
        send_word($urandom, $urandom);
        drain();
    endtask

    // The receiver stops for a long stretch while words keep being offered.
    task automatic test_output_stall();
        configure(24, 3, 4, 1'b1);
        rx_long_hold = 1'b1;
        repeat (12) send_word($urandom, $urandom);
        drain();
    endtask

    task automatic test_random_images();
        int width;
        int rows;
        int pick;
        int n_words;
        while (words_sent < RANDOM_WORDS + 30) begin
            if (words_sent >= RANDOM_WORDS + 30 - QUIET_TAIL) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) width = 0;
            else if (pick == 1) width = $urandom_range(MAX_WIDTH, 8191);
            else if (pick <= 4) width = $urandom_range(17, 100);
            else width = $urandom_range(1, 16);
            pick = $urandom_range(0, 9);
            if (pick == 0) rows = 0;
            else if (pick == 1) rows = $urandom_range(MAX_ROWS, 8191);
            else rows = $urandom_range(1, 5);
            configure(width, rows, $urandom_range(0, 15), 1'($urandom_range(0, 1)));
            n_words = $urandom_range(4, 20);
            repeat (n_words) send_word($urandom, $urandom);
            drain();
        end
    endtask

    // Output side: random ready bursts plus one long hold on request.
    initial begin
        pix_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_long_hold) begin
                pix_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                rx_long_hold = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
                pix_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                pix_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Signals are stable at the falling edge, so a beat seen here is taken at the next rise.
    always @(negedge i_clk) begin
        pixel_beat_t got;
        pixel_beat_t want;
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            got = {pix_ch.pixel_rgba, pix_ch.word_last, pix_ch.row_end, pix_ch.image_end};
            if (pending_pixels.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected pixel beat %h/%b/%b/%b",
                             $realtime, got.rgba, got.word_last, got.row_end, got.image_end);
                mismatch_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want) begin
                    if (mismatch_count < 10)
                        $display("%0t: pixel beat expected %h/%b/%b/%b, got %h/%b/%b/%b",
                                 $realtime, want.rgba, want.word_last, want.row_end,
                                 want.image_end, got.rgba, got.word_last, got.row_end,
                                 got.image_end);
                    mismatch_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || (word_ch.valid && word_ch.ready) || (pix_ch.valid && pix_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin
        quiet_cycles = 0;
        @(posedge i_clk);
        while (quiet_cycles < WATCHDOG_LIMIT) @(negedge i_clk);
        $display("gray2_to_rgba32_unpacker_unit_test: errors");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        word_ch.valid      <= 1'b0;
        word_ch.pixel_word <= '0;
        word_ch.alpha_word <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_ROW_WIDTH;
        cfg_ch.data        <= '0;
        shadow_width   = 13'd1;
        shadow_rows    = 13'd1;
        shadow_start   = '0;
        shadow_alpha   = 1'b0;
        column_pos     = 0;
        row_pos        = 0;
        at_row_start   = 1'b1;
        mismatch_count = 0;
        words_sent     = 0;
        tx_gaps        = 1'b1;
        rx_gaps        = 1'b1;
        rx_long_hold   = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_levels_and_offsets();
        test_zero_and_oversized();
        test_change_mid_image();
        test_output_stall();
        test_random_images();

        drain();
        if (mismatch_count == 0) begin
            $display("gray2_to_rgba32_unpacker_unit_test: clean");
        end else begin
            $display("gray2_to_rgba32_unpacker_unit_test: errors");
        end
        $finish;
    end

endmodule
